FILE: src/plim_pkg.sv
// Package: shared types and constants for the piecewise-linear intensity map.
`timescale 1ns / 1ps
package plim_pkg;

    localparam int DEF_MAX_KNOTS   = 8;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int KNOT_STRIDE     = 16;
    localparam int PIXEL_W         = 16;
    localparam int CFG_W           = 64;
    localparam int ADDR_W          = 6;
    localparam int COUNT_W         = 4;

    localparam logic [COUNT_W-1:0] RST_KNOTS   = 4'd2;
    localparam logic [CFG_W-1:0]   RST_LOW     = 64'h0000_0000_FFFF_0000;
    localparam logic [CFG_W-1:0]   RST_HIGH    = 64'h0;

    typedef enum logic [2:0] {
        REG_KNOTS    = 3'd0,
        REG_IN_LOW   = 3'd1,
        REG_IN_HIGH  = 3'd2,
        REG_OUT_LOW  = 3'd3,
        REG_OUT_HIGH = 3'd4
    } t_reg_idx;

    // flags that ride along the divider chain
    typedef struct packed {
        logic zero;   // zero-width segment: result is lower output knot
        logic neg;    // quotient negative: result is 0
        logic sat;    // quotient past full scale
    } t_side;

endpackage

FILE: src/plim_in_if.sv
// Interface: input pixel stream channel.
`timescale 1ns / 1ps
interface plim_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_in;
    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

FILE: src/plim_out_if.sv
// Interface: mapped pixel stream channel.
`timescale 1ns / 1ps
interface plim_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_out;
    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

FILE: src/piecewise_linear_intensity_map.sv
// Top level: piecewise-linear intensity map with APB registers and output skid stage.
`timescale 1ns / 1ps
// Maps each pixel through a tone curve of 2..MAX_KNOTS knots. One pixel is taken
// every cycle while the skid is empty; from the input transfer, a pixel passes through
// three front stages, then one divider cell per quotient bit, then one output
// register before output valid.
// Throughput: the cell chain retires one quotient per cycle while the skid is empty.
// The output register plus a one-entry skid keep input ready high while a result
// waits; ready drops only once the skid is occupied. Registers sit at 8*i on a
// 64-bit APB port and must be written only while the block is idle.
module piecewise_linear_intensity_map #(
    parameter int MAX_KNOTS   = plim_pkg::DEF_MAX_KNOTS,
    parameter int SAMPLE_BITS = plim_pkg::DEF_SAMPLE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    plim_in_if.sink                     i_px,
    plim_out_if.source                  o_px,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [plim_pkg::ADDR_W-1:0] paddr,
    input  logic [plim_pkg::CFG_W-1:0]  pwdata,
    output logic [plim_pkg::CFG_W-1:0]  prdata,
    output logic                        pready
);
    import plim_pkg::*;

    localparam int W = SAMPLE_BITS;

    // ---------------- configuration registers ----------------
    logic [COUNT_W-1:0] r_knots;
    logic [CFG_W-1:0]   r_in_lo, r_in_hi, r_out_lo, r_out_hi;
    t_reg_idx           reg_sel;
    logic               wr;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_sel = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knots  <= RST_KNOTS;
            r_in_lo  <= RST_LOW;
            r_in_hi  <= RST_HIGH;
            r_out_lo <= RST_LOW;
            r_out_hi <= RST_HIGH;
        end else if (wr) begin
            unique case (reg_sel)
                REG_KNOTS:    r_knots  <= pwdata[COUNT_W-1:0];
                REG_IN_LOW:   r_in_lo  <= pwdata;
                REG_IN_HIGH:  r_in_hi  <= pwdata;
                REG_OUT_LOW:  r_out_lo <= pwdata;
                REG_OUT_HIGH: r_out_hi <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_KNOTS:    prdata = CFG_W'(r_knots);
            REG_IN_LOW:   prdata = r_in_lo;
            REG_IN_HIGH:  prdata = r_in_hi;
            REG_OUT_LOW:  prdata = r_out_lo;
            REG_OUT_HIGH: prdata = r_out_hi;
            default:      prdata = '0;
        endcase
    end

    // knots sit at a fixed 16-bit stride; only the low sample bits count
    logic [2*CFG_W-1:0]                  in_cat, out_cat;
    logic [MAX_KNOTS-1:0][W-1:0]         xs, ys;

    assign in_cat  = {r_in_hi, r_in_lo};
    assign out_cat = {r_out_hi, r_out_lo};

    always_comb begin
        for (int k = 0; k < MAX_KNOTS; k++) begin
            xs[k] = in_cat[k*KNOT_STRIDE +: W];
            ys[k] = out_cat[k*KNOT_STRIDE +: W];
        end
    end

    // ---------------- pipeline ----------------
    logic r_skid_v;
    logic en;
    assign en       = !r_skid_v;     // whole pipeline advances unless skid is full
    assign i_px.ready = en;

    logic         c_valid [W+1];
    logic [W-1:0] c_rem   [W+1];
    logic [W-1:0] c_div   [W+1];
    logic [W-1:0] c_ql    [W+1];
    logic [W-1:0] c_y0    [W+1];
    t_side        c_side  [W+1];

    plim_front #(
        .MAX_KNOTS   (MAX_KNOTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_px.valid),
        .i_pixel (i_px.pixel_in),
        .i_count (r_knots),
        .i_xs    (xs),
        .i_ys    (ys),
        .o_valid (c_valid[0]),
        .o_rem   (c_rem[0]),
        .o_div   (c_div[0]),
        .o_ql    (c_ql[0]),
        .o_y0    (c_y0[0]),
        .o_side  (c_side[0])
    );

    // one cell per quotient bit
    for (genvar g = 0; g < W; g++) begin : g_cell
        plim_div_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[g]),
            .i_rem   (c_rem[g]),
            .i_div   (c_div[g]),
            .i_ql    (c_ql[g]),
            .i_y0    (c_y0[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_div   (c_div[g+1]),
            .o_ql    (c_ql[g+1]),
            .o_y0    (c_y0[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // final pick: zero width, negative, saturated, or the quotient
    logic [W-1:0] res;
    t_side        fs;
    assign fs = c_side[W];

    always_comb begin
        if (fs.zero)      res = c_y0[W];
        else if (fs.neg)  res = '0;
        else if (fs.sat)  res = '1;
        else              res = c_ql[W];
    end

    // ---------------- output register and skid ----------------
    logic         r_ov;
    logic [W-1:0] r_od, r_sd;
    logic         push;
    assign push = en && c_valid[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (o_px.ready || !r_ov) begin
            if (r_skid_v) begin
                r_ov     <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_ov <= push;
            end
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_px.ready || !r_ov) begin
            r_od <= r_skid_v ? r_sd : res;
        end else if (push) begin
            r_sd <= res;
        end
    end

    assign o_px.valid     = r_ov;
    assign o_px.pixel_out = PIXEL_W'(r_od);

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_ov)
        else $error("skid holds data while output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_ov && !o_px.ready && c_valid[W]))
        else $error("skid filled without a stalled output");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && o_px.ready) |=> (r_ov && !r_skid_v))
        else $error("skid entry lost on drain");

    a_ready_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_px.ready == !r_skid_v)
        else $error("input ready out of step with skid state");

endmodule

FILE: src/plim_front.sv
// Front pipeline: clamp, segment search, products and divider setup.
`timescale 1ns / 1ps
module plim_front #(
    parameter int MAX_KNOTS   = plim_pkg::DEF_MAX_KNOTS,
    parameter int SAMPLE_BITS = plim_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [plim_pkg::PIXEL_W-1:0]         i_pixel,
    input  logic [plim_pkg::COUNT_W-1:0]         i_count,
    input  logic [MAX_KNOTS-1:0][SAMPLE_BITS-1:0] i_xs,
    input  logic [MAX_KNOTS-1:0][SAMPLE_BITS-1:0] i_ys,
    output logic                                 o_valid,
    output logic [SAMPLE_BITS-1:0]               o_rem,
    output logic [SAMPLE_BITS-1:0]               o_div,
    output logic [SAMPLE_BITS-1:0]               o_ql,
    output logic [SAMPLE_BITS-1:0]               o_y0,
    output plim_pkg::t_side                      o_side
);
    import plim_pkg::*;

    localparam int W  = SAMPLE_BITS;
    localparam int KI = (MAX_KNOTS > 2) ? $clog2(MAX_KNOTS) : 1;
    localparam int PW = 2 * W + 2;
    localparam int NW = 2 * W + 3;

    // stage A: clamp and segment pick
    logic [COUNT_W-1:0] n_cl;
    logic [KI-1:0]      last, j, jl;
    logic [W-1:0]       v, x_last;

    always_comb begin
        n_cl = i_count;
        if (i_count < COUNT_W'(2)) n_cl = COUNT_W'(2);
        if (i_count > COUNT_W'(MAX_KNOTS)) n_cl = COUNT_W'(MAX_KNOTS);
        last   = KI'(n_cl - COUNT_W'(1));
        x_last = i_xs[last];
        v      = i_pixel[W-1:0];
        if (v > x_last) v = x_last;
        if (v < i_xs[0]) v = i_xs[0];   // lower clamp wins on reversed bounds
        j = last;
        for (int k = MAX_KNOTS - 1; k >= 1; k--) begin
            if (KI'(k) <= last && v <= i_xs[k]) j = KI'(k);
        end
        jl = j - KI'(1);
    end

    logic         r_a_valid;
    logic [W-1:0] r_a_v, r_a_x0, r_a_x1, r_a_y0, r_a_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
        if (i_en) begin
            r_a_v  <= v;
            r_a_x0 <= i_xs[jl];
            r_a_x1 <= i_xs[j];
            r_a_y0 <= i_ys[jl];
            r_a_y1 <= i_ys[j];
        end
    end

    // stage B: differences and the two products
    logic signed [W:0]    dx, dv, dy;
    logic signed [PW-1:0] p0, p1;

    always_comb begin
        dx = $signed({1'b0, r_a_x1}) - $signed({1'b0, r_a_x0});
        dv = $signed({1'b0, r_a_v})  - $signed({1'b0, r_a_x0});
        dy = $signed({1'b0, r_a_y1}) - $signed({1'b0, r_a_y0});
        p0 = $signed({1'b0, r_a_y0}) * dx;
        p1 = dv * dy;
    end

    logic                 r_b_valid;
    logic signed [PW-1:0] r_b_p0, r_b_p1;
    logic signed [W:0]    r_b_dx;
    logic [W-1:0]         r_b_y0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
        if (i_en) begin
            r_b_p0 <= p0;
            r_b_p1 <= p1;
            r_b_dx <= dx;
            r_b_y0 <= r_a_y0;
        end
    end

    // stage C: sign-magnitude split and full-scale test
    logic signed [NW-1:0] num;
    logic [NW-1:0]        mag;
    logic [W-1:0]         dmag;
    t_side                side;

    always_comb begin
        num  = NW'(r_b_p0) + NW'(r_b_p1);
        mag  = num[NW-1] ? NW'(-num) : NW'(num);
        dmag = r_b_dx[W] ? W'(-r_b_dx) : W'(r_b_dx);
        side.zero = (r_b_dx == '0);
        side.neg  = num[NW-1] ^ r_b_dx[W];
        side.sat  = (mag >= {{(NW - 2 * W){1'b0}}, dmag, {W{1'b0}}});
    end

    logic         r_c_valid;
    logic [W-1:0] r_c_rem, r_c_div, r_c_ql, r_c_y0;
    t_side        r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= r_b_valid;
        end
        if (i_en) begin
            r_c_rem  <= mag[2*W-1:W];
            r_c_ql   <= mag[W-1:0];
            r_c_div  <= dmag;
            r_c_y0   <= r_b_y0;
            r_c_side <= side;
        end
    end

    assign o_valid = r_c_valid;
    assign o_rem   = r_c_rem;
    assign o_div   = r_c_div;
    assign o_ql    = r_c_ql;
    assign o_y0    = r_c_y0;
    assign o_side  = r_c_side;

endmodule

FILE: src/plim_div_cell.sv
// Divider cell: one restoring quotient bit per cell, registered toward the next cell.
`timescale 1ns / 1ps
module plim_div_cell #(
    parameter int SAMPLE_BITS = plim_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_rem,
    input  logic [SAMPLE_BITS-1:0] i_div,
    input  logic [SAMPLE_BITS-1:0] i_ql,
    input  logic [SAMPLE_BITS-1:0] i_y0,
    input  plim_pkg::t_side        i_side,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_rem,
    output logic [SAMPLE_BITS-1:0] o_div,
    output logic [SAMPLE_BITS-1:0] o_ql,
    output logic [SAMPLE_BITS-1:0] o_y0,
    output plim_pkg::t_side        o_side
);
    import plim_pkg::*;

    localparam int W = SAMPLE_BITS;

    // ql holds remaining dividend bits on top, quotient bits shifting in below
    logic [W:0]   trial;
    logic         ge;
    logic [W-1:0] n_rem, n_ql;

    always_comb begin
        trial = {i_rem, i_ql[W-1]};
        ge    = (trial >= {1'b0, i_div});
        n_rem = ge ? W'(trial - {1'b0, i_div}) : W'(trial);
        n_ql  = {i_ql[W-2:0], ge};
    end

    logic         r_valid;
    logic [W-1:0] r_rem, r_div, r_ql, r_y0;
    t_side        r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_rem  <= n_rem;
            r_div  <= i_div;
            r_ql   <= n_ql;
            r_y0   <= i_y0;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_ql    = r_ql;
    assign o_y0    = r_y0;
    assign o_side  = r_side;

endmodule

FILE: dv/piecewise_linear_intensity_map_test.sv
// Testbench: piecewise-linear intensity map, checked against a local curve predictor.
`timescale 1ns / 1ps
module piecewise_linear_intensity_map_test;
    import plim_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;  // comfortably past the pipeline depth
    localparam int N_PHASES       = 9;
    localparam int ITEMS_PER_PHASE = 50;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [CFG_W-1:0]  pwdata = '0;
    logic [CFG_W-1:0]  prdata;
    logic              pready;

    plim_in_if  px_in ();
    plim_out_if px_out ();

    piecewise_linear_intensity_map u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_px(px_in.sink), .o_px(px_out.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Local copy of the curve registers.
    logic [COUNT_W-1:0] cur_knots;
    logic [CFG_W-1:0]   cur_in_low, cur_in_high, cur_out_low, cur_out_high;

    logic [15:0] expected_pixels[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles = 0;    // long receiver hold-off, counted down by the receiver
    bit          transfer_seen;

    // Curve predictor: clamp, pick segment, interpolate with truncation, saturate.
    function automatic logic [15:0] map_intensity(input logic [15:0] pix);
        longint xs[8];
        longint ys[8];
        longint v, x0, x1, y0, y1, dx, res;
        int n, j;
        logic [CFG_W-1:0] w;
        n = int'(cur_knots);
        if (n < 2) n = 2;
        if (n > DEF_MAX_KNOTS) n = DEF_MAX_KNOTS;
        for (int k = 0; k < 8; k++) begin
            w = (k < 4) ? cur_in_low : cur_in_high;
            xs[k] = longint'(w[(k % 4) * KNOT_STRIDE +: 16]);
            w = (k < 4) ? cur_out_low : cur_out_high;
            ys[k] = longint'(w[(k % 4) * KNOT_STRIDE +: 16]);
        end
        v = longint'(pix);
        if (v > xs[n-1]) v = xs[n-1];
        // lower clamp last: reversed bounds land on the first knot
        if (v < xs[0]) v = xs[0];
        j = n - 1;
        for (int k = 1; k < n; k++) begin
            if (v <= xs[k]) begin
                j = k;
                break;
            end
        end
        x0 = xs[j-1]; x1 = xs[j]; y0 = ys[j-1]; y1 = ys[j];
        dx = x1 - x0;
        if (dx == 0) begin
            res = y0;  // zero-width segment
        end else begin
            res = (y0 * dx + (v - x0) * (y1 - y0)) / dx;
        end
        if (res < 0) res = 0;
        if (res > 65535) res = 65535;
        return res[15:0];
    endfunction

    // APB write: setup cycle, then access cycle; pready is always high.
    task automatic reg_write(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KNOTS:    cur_knots    = val[COUNT_W-1:0];
            REG_IN_LOW:   cur_in_low   = val;
            REG_IN_HIGH:  cur_in_high  = val;
            REG_OUT_LOW:  cur_out_low  = val;
            REG_OUT_HIGH: cur_out_high = val;
            default: ;
        endcase
    endtask

    task automatic load_curve(input logic [3:0] n, input logic [63:0] il, input logic [63:0] ih,
                              input logic [63:0] ol, input logic [63:0] oh);
        reg_write(REG_KNOTS, 64'(n));
        reg_write(REG_IN_LOW, il);
        reg_write(REG_IN_HIGH, ih);
        reg_write(REG_OUT_LOW, ol);
        reg_write(REG_OUT_HIGH, oh);
    endtask

    // Offer one pixel; returns once the transfer has happened.
    task automatic send_pixel(input logic [15:0] pix, input bit has_fixed,
                              input logic [15:0] fixed_val);
        while ($urandom_range(99) < send_idle_pct) begin
            px_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        px_in.valid    <= 1'b1;
        px_in.pixel_in <= pix;
        do @(posedge i_clk); while (!px_in.ready);
        expected_pixels.push_back(has_fixed ? fixed_val : map_intensity(pix));
    endtask

    task automatic wait_drained();
        px_in.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Pixels biased toward the input knots so every segment gets traffic.
    function automatic logic [15:0] pick_pixel();
        int k;
        logic [CFG_W-1:0] w;
        logic [15:0] base;
        if ($urandom_range(2) == 0) return 16'($urandom);
        k = $urandom_range(7);
        w = (k < 4) ? cur_in_low : cur_in_high;
        base = w[(k % 4) * KNOT_STRIDE +: 16];
        return base + 16'($urandom_range(6)) - 16'd3;
    endfunction

    function automatic logic [63:0] sorted_knots();
        logic [15:0] a[4];
        for (int i = 0; i < 4; i++) a[i] = 16'($urandom);
        a.sort();
        return {a[3], a[2], a[1], a[0]};
    endfunction

    // Receiver: random stalls plus a long counted hold-off on request.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            px_out.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else begin
            px_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && px_out.valid && px_out.ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel_out %h", $time, px_out.pixel_out);
                error_count++;
            end else begin
                logic [15:0] exp_pix;
                exp_pix = expected_pixels.pop_front();
                if (px_out.pixel_out !== exp_pix) begin
                    $display("%0t: pixel_out expected %h actual %h",
                             $time, exp_pix, px_out.pixel_out);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: cycles without any transfer on either channel.
    always @(posedge i_clk) begin
        int idle_count;
        transfer_seen = (px_in.valid && px_in.ready) || (px_out.valid && px_out.ready);
        if (transfer_seen || !i_rst_n) idle_count = 0;
        else idle_count++;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("piecewise_linear_intensity_map_test: errors");
            $finish;
        end
    end

    typedef struct {
        logic [15:0] pixel;
        logic [15:0] fixed_out;
        bit          has_fixed;
    } t_directed_row;

    // Reset curve is identity, so outputs are read off directly.
    t_directed_row directed_rows[] = '{
        '{16'h0000, 16'h0000, 1'b1}, '{16'hFFFF, 16'hFFFF, 1'b1},
        '{16'h0001, 16'h0001, 1'b1}, '{16'h8000, 16'h8000, 1'b1},
        '{16'h7FFF, 16'h7FFF, 1'b1}, '{16'h5555, 16'h5555, 1'b1},
        '{16'hAAAA, 16'hAAAA, 1'b1}, '{16'hFFFE, 16'hFFFE, 1'b1}
    };

    initial begin
        px_in.valid    = 1'b0;
        px_in.pixel_in = '0;
        px_out.ready   = 1'b0;
        cur_knots    = RST_KNOTS;
        cur_in_low   = RST_LOW;
        cur_in_high  = RST_HIGH;
        cur_out_low  = RST_LOW;
        cur_out_high = RST_HIGH;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_pixel(directed_rows[i].pixel, directed_rows[i].has_fixed,
                       directed_rows[i].fixed_out);
        wait_drained();

        // Special curves, predictor-checked.
        // reversed bounds: first input knot above the last
        load_curve(4'd2, 64'h0000_0000_1000_F000, 64'h0, 64'h0000_0000_FFFF_0100, 64'h0);
        send_pixel(16'h0000, 1'b0, 16'h0); send_pixel(16'hFFFF, 1'b0, 16'h0);
        send_pixel(16'h8000, 1'b0, 16'h0);
        wait_drained();
        // a zero-width segment in the curve, and an output knot at full scale
        load_curve(4'd4, 64'hFFFF_8000_8000_0000, 64'h0, 64'h0000_FFFF_1234_0000, 64'h0);
        send_pixel(16'h8000, 1'b0, 16'h0); send_pixel(16'h7FFF, 1'b0, 16'h0);
        send_pixel(16'h8001, 1'b0, 16'h0); send_pixel(16'hFFFF, 1'b0, 16'h0);
        wait_drained();
        // knot count below range and above range
        load_curve(4'd0, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_pixel(16'h4000, 1'b0, 16'h0);
        wait_drained();
        load_curve(4'd15, 64'h0000_FFFF_0000_FFFF, 64'hFFFF_0000_FFFF_0000,
                   64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF);
        send_pixel(16'h0000, 1'b0, 16'h0); send_pixel(16'h9999, 1'b0, 16'h0);
        send_pixel(16'hFFFF, 1'b0, 16'h0);
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph / 3)
                0: begin send_idle_pct = 10; recv_idle_pct = 66; end
                1: begin send_idle_pct = 66; recv_idle_pct = 10; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (ph)
                0: load_curve(4'd8, 64'h5FFF_3FFF_1FFF_0000, 64'hFFFF_DFFF_BFFF_9FFF,
                              64'h9000_4000_1000_0000, 64'hFFFF_F000_E000_C000);
                1: load_curve(4'd1, sorted_knots(), 64'($urandom) << 32 | 64'($urandom),
                              {32'($urandom), 32'($urandom)}, 64'h0);
                2: load_curve(4'd8, sorted_knots(), sorted_knots(),
                              {32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)});
                // unordered everything: saturation and reversed segments
                default: load_curve(4'($urandom_range(2, 15)), {32'($urandom), 32'($urandom)},
                                    {32'($urandom), 32'($urandom)},
                                    {32'($urandom), 32'($urandom)},
                                    {32'($urandom), 32'($urandom)});
            endcase
            if (ph == 6) hold_cycles = 200;  // back up the pipe, input must stall
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_pixel(pick_pixel(), 1'b0, 16'h0);
            wait_drained();  // sender stays quiet until every result is back
        end

        if (error_count == 0) begin
            $display("piecewise_linear_intensity_map_test: clean");
        end else begin
            $display("piecewise_linear_intensity_map_test: errors");
        end
        $finish;
    end

endmodule
